// ===== sv/ebpc_pkg.sv =====
// Shared types, step counts and iteration functions for the disc pair collision pipeline.
// Depends on nothing; every pipeline module and the top level import it.
package ebpc_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 33;

   typedef struct packed {
      logic               collided;
      logic               degenerate;
      logic               dx_neg;
      logic               dy_neg;
      logic [32:0]        mx;
      logic [32:0]        my;
      logic [30:0]        ma;
      logic [30:0]        mb;
      logic [31:0]        total;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
   } side_type;

   typedef struct packed {
      logic [33:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
   } sqrt_lane_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [32:0] quo;
   } div_lane_type;

   // One result bit of the floor square root: two radicand bits enter per step.
   function automatic sqrt_lane_type sqrt_step(sqrt_lane_type s);
      sqrt_lane_type o;
      logic [35:0]   acc;
      logic [35:0]   trial;
      logic          ge;
      acc   = {s.rem, s.rad[63:62]};
      trial = {2'b00, s.root, 2'b01};
      ge    = (acc >= trial);
      if (ge) begin
         acc = acc - trial;
      end
      o.rem  = acc[33:0];
      o.root = {s.root[30:0], ge};
      o.rad  = {s.rad[61:0], 2'b00};
      return o;
   endfunction

   // One quotient bit of a restoring division; the quotient shifts in as the dividend shifts out.
   function automatic div_lane_type div_step(div_lane_type s, logic [31:0] den);
      div_lane_type o;
      logic [32:0]  acc;
      logic         ge;
      acc = {s.rem, s.quo[32]};
      ge  = (acc >= {1'b0, den});
      if (ge) begin
         acc = acc - {1'b0, den};
      end
      o.rem = acc[31:0];
      o.quo = {s.quo[31:0], ge};
      return o;
   endfunction

endpackage

// ===== sv/ebpc_front.sv =====
// Front end: differences, magnitudes, squares and the overlap test over four stages.
// Depends on ebpc_pkg.
module ebpc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [31:0]   ax,
   input  logic signed [31:0]   ay,
   input  logic signed [31:0]   bx,
   input  logic signed [31:0]   by,
   input  logic [30:0]          ra,
   input  logic [30:0]          rb,
   input  logic [30:0]          ma,
   input  logic [30:0]          mb,
   input  logic signed [31:0]   vax,
   input  logic signed [31:0]   vay,
   input  logic signed [31:0]   vbx,
   input  logic signed [31:0]   vby,
   output logic                 out_valid,
   output ebpc_pkg::side_type   out_side,
   output logic [63:0]          out_dist2
);
   import ebpc_pkg::*;

   typedef struct packed {
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dvx;
      logic signed [32:0] dvy;
      logic [31:0]        rsum;
      logic [31:0]        total;
      logic [30:0]        ma;
      logic [30:0]        mb;
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
   } f1_type;

   typedef struct packed {
      side_type    sd;
      logic [31:0] rsum;
   } f2_type;

   typedef struct packed {
      side_type    sd;
      logic [63:0] sx;
      logic [63:0] sy;
      logic [63:0] rsum2;
   } f3_type;

   logic [3:0]  vld_ff, vld_in;
   f1_type      f1_ff, f1_in;
   f2_type      f2_ff, f2_in;
   f3_type      f3_ff, f3_in;
   side_type    side_ff, side_in;
   logic [63:0] dist2_ff, dist2_in;
   logic [64:0] dist_sum;

   always_comb begin
      vld_in = {vld_ff[2:0], in_valid};

      f1_in.dx    = {bx[31], bx} - {ax[31], ax};
      f1_in.dy    = {by[31], by} - {ay[31], ay};
      f1_in.dvx   = {vax[31], vax} - {vbx[31], vbx};
      f1_in.dvy   = {vay[31], vay} - {vby[31], vby};
      f1_in.rsum  = {1'b0, ra} + {1'b0, rb};
      f1_in.total = {1'b0, ma} + {1'b0, mb};
      f1_in.ma    = ma;
      f1_in.mb    = mb;
      f1_in.vax   = vax;
      f1_in.vay   = vay;
      f1_in.vbx   = vbx;
      f1_in.vby   = vby;

      f2_in.sd.collided   = 1'b0;
      f2_in.sd.degenerate = (f1_ff.dx == '0) && (f1_ff.dy == '0);
      f2_in.sd.dx_neg     = f1_ff.dx[32];
      f2_in.sd.dy_neg     = f1_ff.dy[32];
      f2_in.sd.mx         = f1_ff.dx[32] ? 33'(-f1_ff.dx) : 33'(f1_ff.dx);
      f2_in.sd.my         = f1_ff.dy[32] ? 33'(-f1_ff.dy) : 33'(f1_ff.dy);
      f2_in.sd.ma         = f1_ff.ma;
      f2_in.sd.mb         = f1_ff.mb;
      f2_in.sd.total      = f1_ff.total;
      f2_in.sd.dvx        = f1_ff.dvx;
      f2_in.sd.dvy        = f1_ff.dvy;
      f2_in.sd.vax        = f1_ff.vax;
      f2_in.sd.vay        = f1_ff.vay;
      f2_in.sd.vbx        = f1_ff.vbx;
      f2_in.sd.vby        = f1_ff.vby;
      f2_in.rsum          = f1_ff.rsum;

      f3_in.sd    = f2_ff.sd;
      f3_in.sx    = 64'(f2_ff.sd.mx) * 64'(f2_ff.sd.mx);
      f3_in.sy    = 64'(f2_ff.sd.my) * 64'(f2_ff.sd.my);
      f3_in.rsum2 = 64'(f2_ff.rsum) * 64'(f2_ff.rsum);

      dist_sum         = {1'b0, f3_ff.sx} + {1'b0, f3_ff.sy};
      side_in          = f3_ff.sd;
      side_in.collided = !dist_sum[64] && (dist_sum[63:0] < f3_ff.rsum2)
                         && !f3_ff.sd.degenerate;
      dist2_in         = dist_sum[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_ff    <= f1_in;
         f2_ff    <= f2_in;
         f3_ff    <= f3_in;
         side_ff  <= side_in;
         dist2_ff <= dist2_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_side  = side_ff;
   assign out_dist2 = dist2_ff;

endmodule

// ===== sv/ebpc_sqrt.sv =====
// Pipelined floor square root of the squared centre distance, one result bit per stage.
// Depends on ebpc_pkg.
module ebpc_sqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ebpc_pkg::side_type   in_side,
   input  logic [63:0]          in_rad,
   output logic                 out_valid,
   output ebpc_pkg::side_type   out_side,
   output logic [31:0]          out_len
);
   import ebpc_pkg::*;

   logic [SQRT_STEPS-1:0] vld_ff, vld_in;
   sqrt_lane_type         lane_ff [SQRT_STEPS];
   sqrt_lane_type         lane_in [SQRT_STEPS];
   side_type              side_ff [SQRT_STEPS];
   side_type              side_in [SQRT_STEPS];
   sqrt_lane_type         start;

   always_comb begin
      start.rem  = '0;
      start.root = '0;
      start.rad  = in_rad;
      vld_in     = {vld_ff[SQRT_STEPS-2:0], in_valid};
      lane_in[0] = sqrt_step(start);
      side_in[0] = in_side;
      for (int i = 1; i < SQRT_STEPS; i++) begin
         lane_in[i] = sqrt_step(lane_ff[i-1]);
         side_in[i] = side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SQRT_STEPS; i++) begin
            lane_ff[i] <= lane_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];
   assign out_len   = lane_ff[SQRT_STEPS-1].root;

endmodule

// ===== sv/ebpc_div.sv =====
// Four pipelined restoring dividers side by side: both normal components and both mass weights.
// Depends on ebpc_pkg.
module ebpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ebpc_pkg::side_type   in_side,
   input  logic [31:0]          in_len,
   output logic                 out_valid,
   output ebpc_pkg::side_type   out_side,
   output logic [32:0]          out_qnx,
   output logic [32:0]          out_qny,
   output logic [32:0]          out_qwa,
   output logic [32:0]          out_qwb
);
   import ebpc_pkg::*;

   typedef struct packed {
      div_lane_type nx;
      div_lane_type ny;
      div_lane_type wa;
      div_lane_type wb;
      logic [31:0]  len;
      side_type     sd;
   } dstage_type;

   logic [DIV_STEPS-1:0] vld_ff, vld_in;
   dstage_type           stage_ff [DIV_STEPS];
   dstage_type           stage_in [DIV_STEPS];
   dstage_type           start;

   function automatic dstage_type advance(dstage_type s);
      dstage_type o;
      o     = s;
      o.nx  = div_step(s.nx, s.len);
      o.ny  = div_step(s.ny, s.len);
      o.wa  = div_step(s.wa, s.sd.total);
      o.wb  = div_step(s.wb, s.sd.total);
      return o;
   endfunction

   always_comb begin
      start.nx.rem = {2'b00, in_side.mx[32:3]};
      start.nx.quo = {in_side.mx[2:0], 30'd0};
      start.ny.rem = {2'b00, in_side.my[32:3]};
      start.ny.quo = {in_side.my[2:0], 30'd0};
      start.wa.rem = {2'b00, in_side.ma[30:1]};
      start.wa.quo = {in_side.ma[0], 32'd0};
      start.wb.rem = {2'b00, in_side.mb[30:1]};
      start.wb.quo = {in_side.mb[0], 32'd0};
      start.len    = in_len;
      start.sd     = in_side;
      vld_in       = {vld_ff[DIV_STEPS-2:0], in_valid};
      stage_in[0]  = advance(start);
      for (int i = 1; i < DIV_STEPS; i++) begin
         stage_in[i] = advance(stage_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STEPS; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign out_valid = vld_ff[DIV_STEPS-1];
   assign out_side  = stage_ff[DIV_STEPS-1].sd;
   assign out_qnx   = stage_ff[DIV_STEPS-1].nx.quo;
   assign out_qny   = stage_ff[DIV_STEPS-1].ny.quo;
   assign out_qwa   = stage_ff[DIV_STEPS-1].wa.quo;
   assign out_qwb   = stage_ff[DIV_STEPS-1].wb.quo;

endmodule

// ===== sv/ebpc_back.sv =====
// Back end: projection, impulse scaling and saturated velocity update over nine stages.
// Depends on ebpc_pkg.
module ebpc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ebpc_pkg::side_type   in_side,
   input  logic [32:0]          in_qnx,
   input  logic [32:0]          in_qny,
   input  logic [32:0]          in_qwa,
   input  logic [32:0]          in_qwb,
   output logic                 out_valid,
   output logic                 out_collided,
   output logic                 out_degenerate,
   output logic signed [31:0]   out_vax,
   output logic signed [31:0]   out_vay,
   output logic signed [31:0]   out_vbx,
   output logic signed [31:0]   out_vby
);
   import ebpc_pkg::*;

   typedef struct packed {
      side_type           sd;
      logic signed [31:0] nx;
      logic signed [31:0] ny;
      logic [30:0]        nxm;
      logic [30:0]        nym;
      logic [31:0]        wa;
      logic [31:0]        wb;
   } b1_type;

   typedef struct packed {
      side_type           sd;
      logic signed [63:0] px;
      logic signed [63:0] py;
      logic [30:0]        nxm;
      logic [30:0]        nym;
      logic [31:0]        wa;
      logic [31:0]        wb;
   } b2_type;

   typedef struct packed {
      side_type           sd;
      logic signed [63:0] s;
      logic [30:0]        nxm;
      logic [30:0]        nym;
      logic [31:0]        wa;
      logic [31:0]        wb;
   } b3_type;

   typedef struct packed {
      side_type    sd;
      logic [63:0] t;
      logic        sneg;
      logic [30:0] nxm;
      logic [30:0] nym;
      logic [31:0] wa;
      logic [31:0] wb;
   } b4_type;

   typedef struct packed {
      side_type    sd;
      logic [63:0] ta_hi;
      logic [63:0] ta_lo;
      logic [63:0] tb_hi;
      logic [63:0] tb_lo;
      logic        sneg;
      logic [30:0] nxm;
      logic [30:0] nym;
   } b5_type;

   typedef struct packed {
      side_type    sd;
      logic [63:0] ka;
      logic [63:0] kb;
      logic        sneg;
      logic [30:0] nxm;
      logic [30:0] nym;
   } b6_type;

   typedef struct packed {
      side_type         sd;
      logic [3:0][62:0] ph;
      logic [3:0][62:0] pl;
      logic [3:0]       neg;
   } b7_type;

   typedef struct packed {
      side_type         sd;
      logic [3:0][35:0] mag;
      logic [3:0]       neg;
   } b8_type;

   typedef struct packed {
      logic               collided;
      logic               degenerate;
      logic signed [31:0] vax;
      logic signed [31:0] vay;
      logic signed [31:0] vbx;
      logic signed [31:0] vby;
   } res_type;

   function automatic logic [31:0] update(logic signed [31:0] v, logic [35:0] mag, logic neg);
      logic [37:0] wide;
      logic [37:0] m;
      logic [37:0] r;
      wide = {{6{v[31]}}, v};
      m    = {2'b00, mag};
      r    = neg ? wide - m : wide + m;
      if (r[37:31] == {7{r[37]}}) begin
         return r[31:0];
      end else if (r[37]) begin
         return 32'h8000_0000;
      end else begin
         return 32'h7FFF_FFFF;
      end
   endfunction

   logic [8:0]         vld_ff, vld_in;
   b1_type             b1_ff, b1_in;
   b2_type             b2_ff, b2_in;
   b3_type             b3_ff, b3_in;
   b4_type             b4_ff, b4_in;
   b5_type             b5_ff, b5_in;
   b6_type             b6_ff, b6_in;
   b7_type             b7_ff, b7_in;
   b8_type             b8_ff, b8_in;
   res_type            res_ff, res_in;
   logic signed [64:0] px_full;
   logic signed [64:0] py_full;
   logic [63:0]        smag;
   logic [3:0][63:0]   ksum;
   logic [31:0]        upd0, upd1, upd2, upd3;

   always_comb begin
      vld_in = {vld_ff[7:0], in_valid};

      b1_in.sd  = in_side;
      b1_in.nxm = in_qnx[30:0];
      b1_in.nym = in_qny[30:0];
      b1_in.nx  = in_side.dx_neg ? -$signed({1'b0, in_qnx[30:0]})
                                 : $signed({1'b0, in_qnx[30:0]});
      b1_in.ny  = in_side.dy_neg ? -$signed({1'b0, in_qny[30:0]})
                                 : $signed({1'b0, in_qny[30:0]});
      if (in_side.total == '0) begin
         b1_in.wa = '0;
         b1_in.wb = '0;
      end else begin
         b1_in.wa = in_qwa[32] ? 32'hFFFF_FFFF : in_qwa[31:0];
         b1_in.wb = in_qwb[32] ? 32'hFFFF_FFFF : in_qwb[31:0];
      end

      px_full   = b1_ff.sd.dvx * b1_ff.nx;
      py_full   = b1_ff.sd.dvy * b1_ff.ny;
      b2_in.sd  = b1_ff.sd;
      b2_in.px  = px_full[63:0];
      b2_in.py  = py_full[63:0];
      b2_in.nxm = b1_ff.nxm;
      b2_in.nym = b1_ff.nym;
      b2_in.wa  = b1_ff.wa;
      b2_in.wb  = b1_ff.wb;

      b3_in.sd  = b2_ff.sd;
      b3_in.s   = b2_ff.px + b2_ff.py;
      b3_in.nxm = b2_ff.nxm;
      b3_in.nym = b2_ff.nym;
      b3_in.wa  = b2_ff.wa;
      b3_in.wb  = b2_ff.wb;

      smag       = b3_ff.s[63] ? 64'(-b3_ff.s) : 64'(b3_ff.s);
      b4_in.sd   = b3_ff.sd;
      b4_in.t    = {smag[62:0], 1'b0};
      b4_in.sneg = b3_ff.s[63];
      b4_in.nxm  = b3_ff.nxm;
      b4_in.nym  = b3_ff.nym;
      b4_in.wa   = b3_ff.wa;
      b4_in.wb   = b3_ff.wb;

      b5_in.sd    = b4_ff.sd;
      b5_in.ta_hi = 64'(b4_ff.t[63:32]) * 64'(b4_ff.wa);
      b5_in.ta_lo = 64'(b4_ff.t[31:0]) * 64'(b4_ff.wa);
      b5_in.tb_hi = 64'(b4_ff.t[63:32]) * 64'(b4_ff.wb);
      b5_in.tb_lo = 64'(b4_ff.t[31:0]) * 64'(b4_ff.wb);
      b5_in.sneg  = b4_ff.sneg;
      b5_in.nxm   = b4_ff.nxm;
      b5_in.nym   = b4_ff.nym;

      b6_in.sd   = b5_ff.sd;
      b6_in.ka   = b5_ff.ta_hi + {32'd0, b5_ff.ta_lo[63:32]};
      b6_in.kb   = b5_ff.tb_hi + {32'd0, b5_ff.tb_lo[63:32]};
      b6_in.sneg = b5_ff.sneg;
      b6_in.nxm  = b5_ff.nxm;
      b6_in.nym  = b5_ff.nym;

      b7_in.sd     = b6_ff.sd;
      b7_in.ph[0]  = 63'(b6_ff.ka[63:32]) * 63'(b6_ff.nxm);
      b7_in.pl[0]  = 63'(b6_ff.ka[31:0]) * 63'(b6_ff.nxm);
      b7_in.ph[1]  = 63'(b6_ff.ka[63:32]) * 63'(b6_ff.nym);
      b7_in.pl[1]  = 63'(b6_ff.ka[31:0]) * 63'(b6_ff.nym);
      b7_in.ph[2]  = 63'(b6_ff.kb[63:32]) * 63'(b6_ff.nxm);
      b7_in.pl[2]  = 63'(b6_ff.kb[31:0]) * 63'(b6_ff.nxm);
      b7_in.ph[3]  = 63'(b6_ff.kb[63:32]) * 63'(b6_ff.nym);
      b7_in.pl[3]  = 63'(b6_ff.kb[31:0]) * 63'(b6_ff.nym);
      b7_in.neg[0] = !(b6_ff.sd.dx_neg ^ b6_ff.sneg);
      b7_in.neg[1] = !(b6_ff.sd.dy_neg ^ b6_ff.sneg);
      b7_in.neg[2] = b6_ff.sd.dx_neg ^ b6_ff.sneg;
      b7_in.neg[3] = b6_ff.sd.dy_neg ^ b6_ff.sneg;

      b8_in.sd  = b7_ff.sd;
      b8_in.neg = b7_ff.neg;
      for (int i = 0; i < 4; i++) begin
         ksum[i]      = {1'b0, b7_ff.ph[i]} + {33'd0, b7_ff.pl[i][62:32]};
         b8_in.mag[i] = ksum[i][63:28];
      end

      upd0 = update(b8_ff.sd.vax, b8_ff.mag[0], b8_ff.neg[0]);
      upd1 = update(b8_ff.sd.vay, b8_ff.mag[1], b8_ff.neg[1]);
      upd2 = update(b8_ff.sd.vbx, b8_ff.mag[2], b8_ff.neg[2]);
      upd3 = update(b8_ff.sd.vby, b8_ff.mag[3], b8_ff.neg[3]);
      res_in.collided   = b8_ff.sd.collided;
      res_in.degenerate = b8_ff.sd.degenerate;
      res_in.vax = b8_ff.sd.collided ? $signed(upd0) : b8_ff.sd.vax;
      res_in.vay = b8_ff.sd.collided ? $signed(upd1) : b8_ff.sd.vay;
      res_in.vbx = b8_ff.sd.collided ? $signed(upd2) : b8_ff.sd.vbx;
      res_in.vby = b8_ff.sd.collided ? $signed(upd3) : b8_ff.sd.vby;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b1_ff  <= b1_in;
         b2_ff  <= b2_in;
         b3_ff  <= b3_in;
         b4_ff  <= b4_in;
         b5_ff  <= b5_in;
         b6_ff  <= b6_in;
         b7_ff  <= b7_in;
         b8_ff  <= b8_in;
         res_ff <= res_in;
      end
   end

   assign out_valid      = vld_ff[8];
   assign out_collided   = res_ff.collided;
   assign out_degenerate = res_ff.degenerate;
   assign out_vax        = res_ff.vax;
   assign out_vay        = res_ff.vay;
   assign out_vbx        = res_ff.vbx;
   assign out_vby        = res_ff.vby;

endmodule

// ===== sv/elastic_ball_pair_collision.sv =====
// Top level of the disc pair collision pipeline.
// Depends on ebpc_pkg, ebpc_front, ebpc_sqrt, ebpc_div and ebpc_back.
//
// Usage:
// A request word carries two discs: centres, radii, masses and velocities in
// Q16.16. A response word carries the collided and degenerate flags and the
// four resulting velocity components, saturated to signed Q16.16.
// A word is taken on either channel at a rising edge where its valid is high
// and its stall is low. The block accepts one request word per cycle while no
// response is stalled and passes it through four front stages, one stage per
// square root bit (32), one stage per quotient bit of the four parallel
// dividers (33) and nine back stages. Responses leave in request order.
// When the receiver stalls a valid response, the whole pipeline holds and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// Synchronous reset empties the pipeline; there is no other state and no
// configuration.
module elastic_ball_pair_collision (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [31:0]   req_first_x,
   input  logic signed [31:0]   req_first_y,
   input  logic signed [31:0]   req_second_x,
   input  logic signed [31:0]   req_second_y,
   input  logic [30:0]          req_first_radius,
   input  logic [30:0]          req_second_radius,
   input  logic [30:0]          req_first_mass,
   input  logic [30:0]          req_second_mass,
   input  logic signed [31:0]   req_first_vx,
   input  logic signed [31:0]   req_first_vy,
   input  logic signed [31:0]   req_second_vx,
   input  logic signed [31:0]   req_second_vy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_collided,
   output logic                 rsp_degenerate,
   output logic signed [31:0]   rsp_new_first_vx,
   output logic signed [31:0]   rsp_new_first_vy,
   output logic signed [31:0]   rsp_new_second_vx,
   output logic signed [31:0]   rsp_new_second_vy
);
   import ebpc_pkg::*;

   logic        en;
   logic        front_valid;
   side_type    front_side;
   logic [63:0] front_dist2;
   logic        sqrt_valid;
   side_type    sqrt_side;
   logic [31:0] sqrt_len;
   logic        div_valid;
   side_type    div_side;
   logic [32:0] div_qnx, div_qny, div_qwa, div_qwb;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   ebpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .ax        (req_first_x),
      .ay        (req_first_y),
      .bx        (req_second_x),
      .by        (req_second_y),
      .ra        (req_first_radius),
      .rb        (req_second_radius),
      .ma        (req_first_mass),
      .mb        (req_second_mass),
      .vax       (req_first_vx),
      .vay       (req_first_vy),
      .vbx       (req_second_vx),
      .vby       (req_second_vy),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_dist2 (front_dist2)
   );

   ebpc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_rad    (front_dist2),
      .out_valid (sqrt_valid),
      .out_side  (sqrt_side),
      .out_len   (sqrt_len)
   );

   ebpc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_side   (sqrt_side),
      .in_len    (sqrt_len),
      .out_valid (div_valid),
      .out_side  (div_side),
      .out_qnx   (div_qnx),
      .out_qny   (div_qny),
      .out_qwa   (div_qwa),
      .out_qwb   (div_qwb)
   );

   ebpc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .en             (en),
      .in_valid       (div_valid),
      .in_side        (div_side),
      .in_qnx         (div_qnx),
      .in_qny         (div_qny),
      .in_qwa         (div_qwa),
      .in_qwb         (div_qwb),
      .out_valid      (rsp_valid),
      .out_collided   (rsp_collided),
      .out_degenerate (rsp_degenerate),
      .out_vax        (rsp_new_first_vx),
      .out_vay        (rsp_new_first_vy),
      .out_vbx        (rsp_new_second_vx),
      .out_vby        (rsp_new_second_vy)
   );

endmodule

// ===== sv/ebpc_checker.sv =====
// Port-level checks for the disc pair collision pipeline, bound to the top level.
// Depends on elastic_ball_pair_collision.
module ebpc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_collided,
   input logic                 rsp_degenerate,
   input logic signed [31:0]   rsp_new_first_vx,
   input logic signed [31:0]   rsp_new_first_vy,
   input logic signed [31:0]   rsp_new_second_vx,
   input logic signed [31:0]   rsp_new_second_vy
);

   a_stall_holds_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("Stalled response word was dropped.");

   a_stall_holds_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_new_first_vx) && $stable(rsp_new_first_vy)
         && $stable(rsp_new_second_vx) && $stable(rsp_new_second_vy)
         && $stable(rsp_collided) && $stable(rsp_degenerate))
      else $error("Stalled response word changed.");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_collided && rsp_degenerate))
      else $error("Response is both collided and degenerate.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("Request side stalled without a stalled response.");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Response valid after reset.");

endmodule

bind elastic_ball_pair_collision ebpc_checker u_ebpc_checker (.*);

// ===== tb/sv/elastic_ball_pair_collision_tb.sv =====
// Self-checking testbench for the disc pair collision pipeline.
// Depends on ebpc_pkg and elastic_ball_pair_collision; needs no files or arguments.
// A directed table runs first, then random pairs under varying idle and stall pressure.
module elastic_ball_pair_collision_tb;
   import ebpc_pkg::*;

   typedef struct {
      logic signed [31:0] ax, ay, bx, by;
      logic [30:0]        ra, rb, ma, mb;
      logic signed [31:0] vax, vay, vbx, vby;
   } pair_type;

   typedef struct {
      logic               collided;
      logic               degenerate;
      logic signed [31:0] fvx, fvy, svx, svy;
   } bounce_type;

   typedef struct {
      pair_type   pair;
      bit         known;
      bounce_type want;
   } dir_row_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [31:0] req_first_x = 0, req_first_y = 0, req_second_x = 0, req_second_y = 0;
   logic [30:0]        req_first_radius = 0, req_second_radius = 0;
   logic [30:0]        req_first_mass = 1, req_second_mass = 1;
   logic signed [31:0] req_first_vx = 0, req_first_vy = 0;
   logic signed [31:0] req_second_vx = 0, req_second_vy = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic               rsp_collided, rsp_degenerate;
   logic signed [31:0] rsp_new_first_vx, rsp_new_first_vy;
   logic signed [31:0] rsp_new_second_vx, rsp_new_second_vy;

   bounce_type  pending_bounces[$];
   dir_row_type dir_tab[$];
   int          errors = 0;
   int          n_sent = 0, n_checked = 0, n_collided = 0, n_degenerate = 0;
   int          snd_idle = 14, rcv_idle = 83;
   int          hold_left = 0;

   elastic_ball_pair_collision dut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] rem, res, bit_w;
      rem   = v;
      res   = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > rem) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (rem >= res + bit_w) begin
            rem = rem - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] mass_weight(logic [63:0] m, logic [63:0] total);
      logic [63:0] w;
      if (total == 0) return 0;
      w = (m << 32) / total;
      return (w > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : w;
   endfunction

   function automatic logic signed [31:0] push_velocity(logic signed [31:0] v,
         logic signed [31:0] n, logic [127:0] kmag, bit kneg, bit sub);
      logic [127:0]        nmag, mag;
      logic signed [127:0] r;
      bit                  neg;
      nmag = (n < 0) ? 128'(-n) : 128'(n);
      mag  = ((kmag * nmag) >> 32) >> 28;
      neg  = (n < 0) ^ kneg ^ sub;
      r    = neg ? 128'(v) - $signed(mag) : 128'(v) + $signed(mag);
      if (r > 128'sd2147483647) return 32'sh7FFF_FFFF;
      if (r < -128'sd2147483648) return 32'sh8000_0000;
      return r[31:0];
   endfunction

   function automatic bounce_type predict_bounce(pair_type p);
      bounce_type          o;
      logic signed [33:0]  dx, dy, dvx, dvy;
      logic [63:0]         mx, my, d2, rsum, len, total, wa, wb;
      logic [64:0]         d2c;
      logic signed [31:0]  nx, ny;
      logic signed [63:0]  s;
      logic [63:0]         smag, t;
      logic [127:0]        ka, kb;
      bit                  sneg;
      dx  = 34'(p.bx) - 34'(p.ax);
      dy  = 34'(p.by) - 34'(p.ay);
      mx  = (dx < 0) ? 64'(-dx) : 64'(dx);
      my  = (dy < 0) ? 64'(-dy) : 64'(dy);
      d2c = 65'(mx * mx) + 65'(my * my);
      d2  = d2c[63:0];
      rsum = 64'(p.ra) + 64'(p.rb);
      o.degenerate = (dx == 0 && dy == 0);
      o.collided   = !d2c[64] && d2 < rsum * rsum && !o.degenerate;
      o.fvx = p.vax; o.fvy = p.vay; o.svx = p.vbx; o.svy = p.vby;
      if (o.collided) begin
         len = floor_sqrt(d2);
         nx  = 32'((mx << 30) / len);
         ny  = 32'((my << 30) / len);
         if (dx < 0) nx = -nx;
         if (dy < 0) ny = -ny;
         dvx  = 34'(p.vax) - 34'(p.vbx);
         dvy  = 34'(p.vay) - 34'(p.vby);
         // The projection wraps at 64 bits, as does the doubled magnitude.
         s    = 64'(dvx) * 64'(nx) + 64'(dvy) * 64'(ny);
         sneg = s < 0;
         smag = sneg ? 64'(-s) : 64'(s);
         t    = {smag[62:0], 1'b0};
         total = 64'(p.ma) + 64'(p.mb);
         wa   = mass_weight(64'(p.ma), total);
         wb   = mass_weight(64'(p.mb), total);
         ka   = (128'(t) * 128'(wa)) >> 32;
         kb   = (128'(t) * 128'(wb)) >> 32;
         o.fvx = push_velocity(p.vax, nx, ka, sneg, 1'b1);
         o.fvy = push_velocity(p.vay, ny, ka, sneg, 1'b1);
         o.svx = push_velocity(p.vbx, nx, kb, sneg, 1'b0);
         o.svy = push_velocity(p.vby, ny, kb, sneg, 1'b0);
      end
      return o;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("MISMATCH word %0d %s: got %0d expected %0d", n_checked, field, got, want);
      errors++;
   endtask

   task automatic check_bounce();
      bounce_type w;
      if (pending_bounces.size() == 0) begin
         report_mismatch("unexpected word", 1, 0);
         return;
      end
      w = pending_bounces.pop_front();
      if (rsp_collided !== w.collided) report_mismatch("collided", rsp_collided, w.collided);
      if (rsp_degenerate !== w.degenerate)
         report_mismatch("degenerate", rsp_degenerate, w.degenerate);
      if (rsp_new_first_vx !== w.fvx) report_mismatch("new_first_vx", rsp_new_first_vx, w.fvx);
      if (rsp_new_first_vy !== w.fvy) report_mismatch("new_first_vy", rsp_new_first_vy, w.fvy);
      if (rsp_new_second_vx !== w.svx)
         report_mismatch("new_second_vx", rsp_new_second_vx, w.svx);
      if (rsp_new_second_vy !== w.svy)
         report_mismatch("new_second_vy", rsp_new_second_vy, w.svy);
      n_checked++;
      n_collided   += w.collided;
      n_degenerate += w.degenerate;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) check_bounce();
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle);
      end
   end

   task automatic send_pair(pair_type p, bit known, bounce_type want);
      bounce_type exp_b;
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_first_x       <= p.ax;  req_first_y       <= p.ay;
      req_second_x      <= p.bx;  req_second_y      <= p.by;
      req_first_radius  <= p.ra;  req_second_radius <= p.rb;
      req_first_mass    <= p.ma;  req_second_mass   <= p.mb;
      req_first_vx      <= p.vax; req_first_vy      <= p.vay;
      req_second_vx     <= p.vbx; req_second_vy     <= p.vby;
      do @(posedge clock); while (req_stall);
      exp_b = known ? want : predict_bounce(p);
      pending_bounces.insert(pending_bounces.size(), exp_b);
      n_sent++;
   endtask

   function automatic logic signed [31:0] rand_word();
      return $signed($urandom) >>> $urandom_range(31);
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int       mode;
      mode  = $urandom_range(9);
      p.ax  = $urandom; p.ay = $urandom;
      p.ma  = 31'($urandom) >> $urandom_range(30);
      p.mb  = 31'($urandom) >> $urandom_range(30);
      if (p.ma == 0) p.ma = 31'd1;
      if (p.mb == 0) p.mb = 31'd1;
      p.vax = rand_word(); p.vay = rand_word();
      p.vbx = rand_word(); p.vby = rand_word();
      if (mode == 0) begin
         p.bx = $urandom; p.by = $urandom;
         p.ra = 31'($urandom); p.rb = 31'($urandom);
         p.ma = 31'($urandom); p.mb = 31'($urandom);
         if (p.ma == 0) p.ma = 31'd1;
         if (p.mb == 0) p.mb = 31'd1;
         p.vax = $urandom; p.vay = $urandom; p.vbx = $urandom; p.vby = $urandom;
      end else if (mode == 1) begin
         p.bx = p.ax; p.by = p.ay;
         p.ra = 31'($urandom); p.rb = 31'($urandom);
      end else begin
         p.bx = p.ax + rand_word();
         p.by = p.ay + rand_word();
         p.ra = 31'($urandom) >> $urandom_range(30);
         p.rb = 31'((p.bx > p.ax ? p.bx - p.ax : p.ax - p.bx)
                  + (p.by > p.ay ? p.by - p.ay : p.ay - p.by)) + 31'($urandom_range(65535));
         if (mode == 9) p.rb = p.rb >> $urandom_range(3);
      end
      return p;
   endfunction

   function automatic pair_type mk_pair(int ax, int ay, int bx, int by, int ra, int rb,
         int ma, int mb, int vax, int vay, int vbx, int vby);
      pair_type p;
      p.ax = ax; p.ay = ay; p.bx = bx; p.by = by;
      p.ra = 31'(ra); p.rb = 31'(rb); p.ma = 31'(ma); p.mb = 31'(mb);
      p.vax = vax; p.vay = vay; p.vbx = vbx; p.vby = vby;
      return p;
   endfunction

   function automatic void add_row(pair_type p, bit known, bit coll, bit degen);
      dir_row_type r;
      r.pair  = p;
      r.known = known;
      r.want.collided   = coll;
      r.want.degenerate = degen;
      r.want.fvx = p.vax; r.want.fvy = p.vay;
      r.want.svx = p.vbx; r.want.svy = p.vby;
      dir_tab.insert(dir_tab.size(), r);
   endfunction

   localparam int ONE  = 32'h0001_0000;
   localparam int MAXI = 32'h7FFF_FFFF;
   localparam int MINI = 32'h8000_0000;
   localparam int MAXU = 31'h7FFF_FFFF;

   initial begin
      bounce_type none;
      none = '{default: 0};
      // Known outcomes: coincident centres, no overlap, touching at equality.
      add_row(mk_pair(0, 0, 0, 0, ONE, ONE, ONE, ONE, ONE, 0, -ONE, 0), 1'b1, 1'b0, 1'b1);
      add_row(mk_pair(MINI, MAXI, MINI, MAXI, MAXU, MAXU, MAXU, 1, MAXI, MINI, MINI, MAXI),
              1'b1, 1'b0, 1'b1);
      add_row(mk_pair(MINI, MINI, MAXI, MAXI, MAXU, MAXU, MAXU, MAXU, MINI, MAXI, MAXI, MINI),
              1'b1, 1'b0, 1'b0);
      add_row(mk_pair(0, 0, 2 * ONE, 0, ONE, ONE, ONE, ONE, ONE, 0, -ONE, 0), 1'b1, 1'b0, 1'b0);
      add_row(mk_pair(0, 0, 0, ONE, 0, 0, 1, 1, 5, 6, 7, 8), 1'b1, 1'b0, 1'b0);
      add_row(mk_pair(MAXI, 0, MINI, 0, MAXU, MAXU, 1, 1, -1, -1, 1, 1), 1'b1, 1'b0, 1'b0);
      // Pairs checked against the predictor; all but two of them overlap.
      add_row(mk_pair(0, 0, ONE, 0, ONE, ONE, ONE, ONE, ONE, 0, -ONE, 0), 1'b0, 1'b0, 1'b0);
      add_row(mk_pair(0, 0, ONE, ONE, ONE, ONE, ONE, 3 * ONE, ONE, ONE, 0, 0),
              1'b0, 1'b0, 1'b0);
      add_row(mk_pair(0, 0, -ONE, -ONE, ONE, ONE, 1, MAXU, 0, 0, ONE, -ONE), 1'b0, 1'b0, 1'b0);
      add_row(mk_pair(0, 0, 0, -3, 2, 2, MAXU, 1, -7, 100, 3, -100), 1'b0, 1'b0, 1'b0);
      add_row(mk_pair(0, 0, 1, 0, 1, 1, 1, 1, MAXI, MAXI, MINI, MINI), 1'b0, 1'b0, 1'b0);
      add_row(mk_pair(MINI, MINI, MAXI, MAXI, MAXU, MAXU, MAXU, MAXU, MAXI, MINI, MINI, MAXI),
              1'b0, 1'b0, 1'b0);
      add_row(mk_pair(MAXI, MAXI, 0, 0, MAXU, MAXU, 1, 1, MINI, MINI, MAXI, MAXI),
              1'b0, 1'b0, 1'b0);
      add_row(mk_pair(100, -ONE, -100, ONE, 2 * ONE, 0, MAXU, MAXU, -ONE, 7, ONE, -7),
              1'b0, 1'b0, 1'b0);
      add_row(mk_pair(0, 0, 3 * ONE, 4 * ONE, 0, 6 * ONE, 2, 1, 0, -ONE, 5 * ONE, 0),
              1'b0, 1'b0, 1'b0);

      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_tab[i]) send_pair(dir_tab[i].pair, dir_tab[i].known, dir_tab[i].want);
      repeat (370) send_pair(random_pair(), 1'b0, none);
      snd_idle = 83; rcv_idle = 14;
      repeat (220) send_pair(random_pair(), 1'b0, none);
      snd_idle = 0; rcv_idle = 0;
      hold_left <= 300;
      repeat (200) send_pair(random_pair(), 1'b0, none);

      req_valid <= 1'b0;
      while (pending_bounces.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d pairs, checked %0d responses (%0d collided, %0d degenerate).",
               n_sent, n_checked, n_collided, n_degenerate);
      $display("Idle mixes and a long receiver hold-off were covered.");
      if (errors == 0) begin
         $display("elastic_ball_pair_collision verification clean");
      end else begin
         $display("elastic_ball_pair_collision verification failed");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("Timeout with %0d responses outstanding.", pending_bounces.size());
      $display("elastic_ball_pair_collision verification failed");
      $finish;
   end

endmodule
